// ===== rtl/core/pbre_pkg.sv =====
package pbre_pkg;

  localparam int CountBits = 16;
  // the repeat counter never grows past 16 bits, so at most five decimal digits
  localparam int CntW      = (CountBits < 16) ? CountBits : 16;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  localparam logic [6:0] CharHash = 7'd35;
  localparam logic [6:0] CharZero = 7'd48;
  localparam logic [6:0] CharA    = 7'd65;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               last_sample;
    logic               empty_sequence;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_item;
    logic       end_of_string;
  } out_item_t;

  // one word of work for the character sequencer
  typedef struct packed {
    logic            aa;        // empty marker: send "AA"
    logic            count_en;  // send '#', count, '#'
    logic [CntW-1:0] count;
    logic [2:0]      top_pos;   // power of ten of the leading digit
    logic            code_en;   // send two base64 symbols
    logic [11:0]     code;
    logic            eos;       // last character closes the string
  } job_t;

  typedef enum logic [2:0] {
    StAa0,
    StAa1,
    StHashOpen,
    StDigit,
    StHashClose,
    StCodeHi,
    StCodeLo
  } step_e;

  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] c;
    c = 7'(idx);
    if (idx < 6'd26) begin
      b64_char = c + 7'd65;
    end else if (idx < 6'd52) begin
      b64_char = c + 7'd71;
    end else if (idx < 6'd62) begin
      b64_char = c - 7'd4;
    end else if (idx == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

  function automatic logic [2:0] top_pos(input logic [CntW-1:0] c);
    logic [16:0] z;
    z = 17'(c);
    if (z >= 17'd10000) begin
      top_pos = 3'd4;
    end else if (z >= 17'd1000) begin
      top_pos = 3'd3;
    end else if (z >= 17'd100) begin
      top_pos = 3'd2;
    end else if (z >= 17'd10) begin
      top_pos = 3'd1;
    end else begin
      top_pos = 3'd0;
    end
  endfunction

  // d times ten to the pos, d a constant of the caller
  function automatic logic [16:0] digit_weight(input logic [2:0] pos, input int d);
    unique case (pos)
      3'd0:    digit_weight = 17'(d);
      3'd1:    digit_weight = 17'(d * 10);
      3'd2:    digit_weight = 17'(d * 100);
      3'd3:    digit_weight = 17'(d * 1000);
      default: digit_weight = 17'(d * 10000);
    endcase
  endfunction

endpackage

// ===== rtl/core/pbre_front.sv =====
module pbre_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pbre_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output pbre_pkg::job_t    job_o
);

  logic [11:0]               prev_q, prev_d;
  logic                      have_q, have_d;
  logic [pbre_pkg::CntW-1:0] count_q, count_d, cnt_inc;
  logic [11:0]               code;
  logic                      accept, want;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && want;

  always_comb begin
    if (in_data_i.sample_value < -16'sd2048) begin
      code = 12'h800;
    end else if (in_data_i.sample_value > 16'sd2047) begin
      code = 12'h7ff;
    end else begin
      code = in_data_i.sample_value[11:0];
    end
    cnt_inc = (count_q == pbre_pkg::CountMax) ? count_q : count_q + 1'b1;

    job_o   = '0;
    want    = 1'b0;
    prev_d  = prev_q;
    have_d  = have_q;
    count_d = count_q;

    priority if (in_data_i.empty_sequence) begin
      // drop any open sequence
      job_o.aa  = 1'b1;
      job_o.eos = 1'b1;
      want      = 1'b1;
      prev_d    = '0;
      have_d    = 1'b0;
      count_d   = '0;
    end else if (!have_q) begin
      job_o.code_en = 1'b1;
      job_o.code    = code;
      want          = 1'b1;
      prev_d        = code;
      have_d        = 1'b1;
      count_d       = '0;
    end else if (code == prev_q) begin
      count_d = cnt_inc;
      if (in_data_i.last_sample) begin
        job_o.count_en = 1'b1;
        job_o.count    = cnt_inc;
        want           = 1'b1;
      end
    end else begin
      job_o.count_en = (count_q != '0);
      job_o.count    = count_q;
      job_o.code_en  = 1'b1;
      job_o.code     = code;
      want           = 1'b1;
      prev_d         = code;
      count_d        = '0;
    end

    job_o.top_pos = pbre_pkg::top_pos(job_o.count);

    if (!in_data_i.empty_sequence && in_data_i.last_sample) begin
      job_o.eos = 1'b1;
      prev_d    = '0;
      have_d    = 1'b0;
      count_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      have_q  <= 1'b0;
      count_q <= '0;
    end else if (accept) begin
      prev_q  <= prev_d;
      have_q  <= have_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/core/pbre_fifo.sv =====
module pbre_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pbre_pkg::job_t push_data_i,
  input  logic           pop_i,
  output pbre_pkg::job_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  pbre_pkg::job_t             mem_q [pbre_pkg::QDepth];
  logic [pbre_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [pbre_pkg::QPtrW:0]   cnt_q;
  logic                       do_pop;

  assign full_o  = (cnt_q == (pbre_pkg::QPtrW+1)'(pbre_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (pbre_pkg::QPtrW+1)'(push_i) - (pbre_pkg::QPtrW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/pbre_back.sv =====
module pbre_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbre_pkg::job_t      head_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output pbre_pkg::out_item_t out_data_o,
  input  logic                out_stall_i
);

  pbre_pkg::step_e           step_q, step_d;
  pbre_pkg::job_t            job_q, job_d;
  logic                      busy_q, busy_d;
  logic [pbre_pkg::CntW-1:0] rem_q, rem_d;
  logic [2:0]                pos_q, pos_d;
  logic                      out_valid_q, out_valid_d;
  pbre_pkg::out_item_t       out_q, out_d;

  logic [6:0]  ch;
  logic        last_ch, advance, load, out_free;
  logic [3:0]  digit;
  logic [16:0] sub;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = busy_q && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    digit = '0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      if (17'(rem_q) >= pbre_pkg::digit_weight(pos_q, d)) begin
        digit = 4'(d);
        sub   = pbre_pkg::digit_weight(pos_q, d);
      end
    end
  end

  always_comb begin
    ch      = pbre_pkg::CharA;
    last_ch = 1'b0;
    step_d  = step_q;
    job_d   = job_q;
    busy_d  = busy_q;
    rem_d   = rem_q;
    pos_d   = pos_q;

    unique case (step_q)
      pbre_pkg::StAa0: begin
        step_d = pbre_pkg::StAa1;
      end
      pbre_pkg::StAa1: begin
        last_ch = 1'b1;
      end
      pbre_pkg::StHashOpen: begin
        ch     = pbre_pkg::CharHash;
        step_d = pbre_pkg::StDigit;
        pos_d  = job_q.top_pos;
      end
      pbre_pkg::StDigit: begin
        ch    = pbre_pkg::CharZero + 7'(digit);
        rem_d = pbre_pkg::CntW'(17'(rem_q) - sub);
        if (pos_q == 3'd0) begin
          step_d = pbre_pkg::StHashClose;
        end else begin
          pos_d = pos_q - 3'd1;
        end
      end
      pbre_pkg::StHashClose: begin
        ch = pbre_pkg::CharHash;
        if (job_q.code_en) begin
          step_d = pbre_pkg::StCodeHi;
        end else begin
          last_ch = 1'b1;
        end
      end
      pbre_pkg::StCodeHi: begin
        ch     = pbre_pkg::b64_char(job_q.code[11:6]);
        step_d = pbre_pkg::StCodeLo;
      end
      pbre_pkg::StCodeLo: begin
        ch      = pbre_pkg::b64_char(job_q.code[5:0]);
        last_ch = 1'b1;
      end
      default: begin
        step_d = pbre_pkg::StAa0;
      end
    endcase

    // hold the sequencer while the output register is blocked
    if (!advance) begin
      step_d = step_q;
      rem_d  = rem_q;
      pos_d  = pos_q;
    end

    load  = !busy_q || (advance && last_ch);
    pop_o = load && !q_empty_i;
    if (pop_o) begin
      job_d  = head_i;
      busy_d = 1'b1;
      rem_d  = head_i.count;
      priority if (head_i.aa) begin
        step_d = pbre_pkg::StAa0;
      end else if (head_i.count_en) begin
        step_d = pbre_pkg::StHashOpen;
      end else begin
        step_d = pbre_pkg::StCodeHi;
      end
    end else if (load) begin
      busy_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d         = 1'b1;
      out_d.out_char      = ch;
      out_d.last_of_item  = last_ch;
      out_d.end_of_string = last_ch && job_q.eos;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pbre_pkg::StAa0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

endmodule

// ===== rtl/core/pitch_bend_base64_rle_encoder.sv =====
// channel | signals                          | word
// --------+----------------------------------+------------------------------------
// in      | in_valid_i, in_stall_o, in_data_i   | sample, last mark, empty marker
// out     | out_valid_o, out_stall_i, out_data_o| one character with end flags
//
// The input side takes one word per cycle while the 4-entry job queue has room.
// The output side sends one character per cycle while out_stall_i is low and work
// is queued; a sample yields two characters if its code is sent, none if it only
// extends a run, and count digits + 2 when a run is reported; the character sequencer in the back end sets the rate.
// Reset clears the run state, the queue and the output valid flag at once.
// A stall on the output holds the sequencer; the queue absorbs input meanwhile.
module pitch_bend_base64_rle_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pbre_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pbre_pkg::out_item_t out_data_o
);

  pbre_pkg::job_t push_job, head_job;
  logic           push, pop, q_full, q_empty;

  pbre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  pbre_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  pbre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== rtl/core/pbre_checker.sv =====
module pbre_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pbre_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pbre_pkg::out_item_t out_data_o
);

  // a stalled word stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed under stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  a_eos_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_string |-> out_data_o.last_of_item)
    else $error("end of string without end of item");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_char >= 7'd35 && out_data_o.out_char <= 7'd122)
    else $error("character out of range");

endmodule

bind pitch_bend_base64_rle_encoder pbre_checker u_pbre_checker (.*);

// ===== tb/pbre_char_checker.sv =====
`timescale 1ns / 1ps

module pbre_char_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  pbre_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  pbre_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  words_o,
  output int                  chars_o
);

  localparam int RunLimit =
    (pbre_pkg::CountBits >= 16) ? 65535 : (1 << pbre_pkg::CountBits) - 1;
  localparam logic [8*64-1:0] B64Symbols =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // run state of the sequence being encoded
  logic [11:0] last_code_q   = '0;
  bit          code_seen_q   = 1'b0;
  logic [15:0] repeat_run_q  = '0;

  pbre_pkg::out_item_t expected_chars[$];
  pbre_pkg::out_item_t burst[$];

  function automatic logic [11:0] pitch_code(input logic signed [15:0] cents);
    if (cents < -16'sd2048) return 12'h800;
    if (cents > 16'sd2047) return 12'h7ff;
    return cents[11:0];
  endfunction

  function automatic logic [6:0] b64_symbol(input logic [5:0] idx);
    return B64Symbols[8*(63 - int'(idx)) +: 7];
  endfunction

  task automatic add_char(input logic [6:0] ch);
    pbre_pkg::out_item_t c;
    c = '0;
    c.out_char = ch;
    burst = {burst, c};
  endtask

  task automatic add_code(input logic [11:0] code);
    add_char(b64_symbol(code[11:6]));
    add_char(b64_symbol(code[5:0]));
  endtask

  task automatic add_run_count(input logic [15:0] count);
    int digits[$];
    int rest;
    rest = count;
    do begin
      digits.push_front(rest % 10);
      rest = rest / 10;
    end while (rest != 0);
    add_char(pbre_pkg::CharHash);
    foreach (digits[i]) add_char(7'(pbre_pkg::CharZero + digits[i]));
    add_char(pbre_pkg::CharHash);
  endtask

  task automatic clear_run();
    last_code_q  = '0;
    code_seen_q  = 1'b0;
    repeat_run_q = '0;
  endtask

  // Work out the characters one input word causes and queue them.
  task automatic encode_word(input pbre_pkg::in_item_t w);
    logic [11:0] code;
    burst.delete();
    if (w.empty_sequence) begin
      // drop any open sequence
      clear_run();
      add_char(pbre_pkg::CharA);
      add_char(pbre_pkg::CharA);
      burst[1].end_of_string = 1'b1;
    end else begin
      code = pitch_code(w.sample_value);
      if (!code_seen_q) begin
        add_code(code);
        last_code_q  = code;
        code_seen_q  = 1'b1;
        repeat_run_q = '0;
      end else if (code == last_code_q) begin
        if (repeat_run_q < RunLimit) repeat_run_q = repeat_run_q + 16'd1;
      end else begin
        if (repeat_run_q != 0) add_run_count(repeat_run_q);
        add_code(code);
        last_code_q  = code;
        repeat_run_q = '0;
      end
      if (w.last_sample) begin
        if (repeat_run_q != 0) add_run_count(repeat_run_q);
        clear_run();
        if (burst.size() > 0) burst[burst.size()-1].end_of_string = 1'b1;
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last_of_item = 1'b1;
    foreach (burst[i]) expected_chars = {expected_chars, burst[i]};
  endtask

  always @(posedge clk_i) begin
    pbre_pkg::out_item_t exp_char;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        encode_word(in_data_i);
        words_o = words_o + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        chars_o = chars_o + 1;
        if (expected_chars.size() == 0) begin
          $error("out_char: nothing expected, got %0d", out_data_i.out_char);
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_char = expected_chars.pop_front();
          if (out_data_i.out_char !== exp_char.out_char) begin
            $error("out_char: expected %0d, got %0d", exp_char.out_char,
                   out_data_i.out_char);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.last_of_item !== exp_char.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d", exp_char.last_of_item,
                   out_data_i.last_of_item);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.end_of_string !== exp_char.end_of_string) begin
            $error("end_of_string: expected %0d, got %0d", exp_char.end_of_string,
                   out_data_i.end_of_string);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

// ===== tb/pitch_bend_base64_rle_encoder_tb.sv =====
`timescale 1ns / 1ps

module pitch_bend_base64_rle_encoder_tb;

  localparam int IdleLimit   = 2000;
  localparam int RandomWords = 60;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  pbre_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b1;
  pbre_pkg::out_item_t out_data_o;

  int fails, pending, words_seen, chars_seen;
  int idle_cycles   = 0;
  int seq_count     = 0;
  int marker_count  = 0;
  int send_mode_left = 0;
  bit send_steady    = 1'b0;

  pitch_bend_base64_rle_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pbre_char_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fails),
    .pending_o    (pending),
    .words_o      (words_seen),
    .chars_o      (chars_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic pbre_pkg::in_item_t make_word(input int cents, input bit last,
                                                   input bit marker);
    pbre_pkg::in_item_t w;
    w.sample_value   = 16'(cents);
    w.last_sample    = last;
    w.empty_sequence = marker;
    return w;
  endfunction

  function automatic int pick_cents();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return int'($urandom_range(0, 4095)) - 2048;
    if (sel == 6) return int'($signed(16'($urandom())));
    if (sel == 7) return int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 5))
      0:       return -2048;
      1:       return 2047;
      2:       return -2049;
      3:       return 2048;
      4:       return 32767;
      default: return -32768;
    endcase
  endfunction

  // Another value with the same code; clamped values may vary beyond the rails.
  function automatic int same_code_cents(input int cents);
    if (cents >= 2047 && $urandom_range(0, 1)) return int'($urandom_range(2047, 32767));
    if (cents <= -2048 && $urandom_range(0, 1)) return -int'($urandom_range(2048, 32768));
    return cents;
  endfunction

  // Present one word; valid stays high after acceptance unless a gap follows.
  task automatic send_word(input pbre_pkg::in_item_t w, input bit hurry);
    int gap;
    bit taken;
    if (hurry) begin
      gap = 0;
    end else begin
      if (send_mode_left == 0) begin
        send_steady    = ($urandom_range(0, 3) == 0);
        send_mode_left = $urandom_range(5, 30);
      end
      send_mode_left = send_mode_left - 1;
      gap = send_steady ? 0 : $urandom_range(0, 12);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (w.empty_sequence) marker_count = marker_count + 1;
    else if (w.last_sample) seq_count = seq_count + 1;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin : receiver
    int gap;
    int mode_left;
    bit steady;
    bit got;
    mode_left = 0;
    steady    = 1'b0;
    @(posedge clk_i);
    forever begin
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(5, 40);
      end
      mode_left = mode_left - 1;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
    end
  end

  initial begin : stimulus
    int random_sent;
    int n_runs;
    int reps;
    int cents;
    int sel;
    bit cut;
    bit last_one;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, clamping, repeats across the rails and the empty marker
    send_word(make_word(0, 1, 0), 0);
    send_word(make_word(32767, 0, 0), 0);
    send_word(make_word(2047, 0, 0), 0);
    send_word(make_word(-32768, 0, 0), 0);
    send_word(make_word(-2048, 0, 0), 0);
    send_word(make_word(-2049, 0, 0), 0);
    send_word(make_word(-1, 0, 0), 0);
    send_word(make_word(1, 1, 0), 0);
    send_word(make_word(-32768, 1, 1), 0);
    // open sequence dropped by a marker
    send_word(make_word(100, 0, 0), 0);
    send_word(make_word(100, 0, 0), 0);
    send_word(make_word(200, 0, 0), 0);
    send_word(make_word(32767, 0, 1), 0);
    // run that ends with the sequence
    send_word(make_word(5, 0, 0), 0);
    send_word(make_word(5, 0, 0), 0);
    send_word(make_word(5, 0, 0), 0);
    send_word(make_word(5, 1, 0), 0);
    send_word(make_word(-1, 1, 0), 0);
    // run ended by a new code on the last sample
    send_word(make_word(9, 0, 0), 0);
    send_word(make_word(9, 0, 0), 0);
    send_word(make_word(10, 1, 0), 0);
    send_word(make_word(2048, 1, 0), 0);
    wait_drained();

    // two-digit count, then a short run ended by a new code on the last sample, back to back
    send_word(make_word(500, 0, 0), 1);
    repeat (11) send_word(make_word(500, 0, 0), 1);
    send_word(make_word(501, 0, 0), 1);
    repeat (3) send_word(make_word(501, 0, 0), 1);
    send_word(make_word(-7, 1, 0), 1);
    wait_drained();

    random_sent = 0;
    while (random_sent < RandomWords) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // marker with noise in the other fields
        send_word(make_word(int'($signed(16'($urandom()))), $urandom_range(0, 1), 1), 0);
        random_sent = random_sent + 1;
      end else begin
        cut    = (sel == 1);
        n_runs = $urandom_range(1, 4);
        for (int r = 0; r < n_runs; r++) begin
          cents = pick_cents();
          sel   = $urandom_range(0, 9);
          if (sel <= 5) reps = 0;
          else if (sel <= 8) reps = $urandom_range(1, 9);
          else reps = $urandom_range(10, 25);
          for (int k = 0; k <= reps; k++) begin
            last_one = (r == n_runs - 1) && (k == reps) && !cut;
            send_word(make_word((k == 0) ? cents : same_code_cents(cents), last_one, 0), 0);
            random_sent = random_sent + 1;
          end
        end
        if (cut) begin
          send_word(make_word(int'($signed(16'($urandom()))), 0, 1), 0);
          random_sent = random_sent + 1;
        end
      end
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d words: %0d sequences and %0d empty markers; %0d characters checked.",
             words_seen, seq_count, marker_count, chars_seen);
    $display("Included rail clamping, one- and two-digit repeat counts, back-to-back runs %s",
             "and sequences cut off by a marker.");
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pbre_pkg.sv
rtl/core/pbre_front.sv
rtl/core/pbre_fifo.sv
rtl/core/pbre_back.sv
rtl/core/pitch_bend_base64_rle_encoder.sv
rtl/core/pbre_checker.sv
tb/pbre_char_checker.sv
tb/pitch_bend_base64_rle_encoder_tb.sv
